// ----- rtl/bqy_pkg.sv -----
// Shared types and constants for the Bayer quad to YCbCr unit.
// Holds the window and pixel beat layouts and the color conversion weights.
// No dependencies.
package bqy_pkg;

    // One input beat: four rows of the 4x4 raw window, column x-1 in the low byte.
    typedef struct packed {
        logic [31:0] window_row0;
        logic [31:0] window_row1;
        logic [31:0] window_row2;
        logic [31:0] window_row3;
    } t_win_beat;

    // One output beat: Y, Cb and Cr bytes for each pixel of the 2x2 quad.
    typedef struct packed {
        logic [7:0] luma_top_left;
        logic [7:0] blue_diff_top_left;
        logic [7:0] red_diff_top_left;
        logic [7:0] luma_top_right;
        logic [7:0] blue_diff_top_right;
        logic [7:0] red_diff_top_right;
        logic [7:0] luma_bottom_left;
        logic [7:0] blue_diff_bottom_left;
        logic [7:0] red_diff_bottom_left;
        logic [7:0] luma_bottom_right;
        logic [7:0] blue_diff_bottom_right;
        logic [7:0] red_diff_bottom_right;
    } t_pix_beat;

    // Converted color of one pixel.
    typedef struct packed {
        logic [7:0] luma;
        logic [7:0] blue_diff;
        logic [7:0] red_diff;
    } t_ycbcr;

    // Color weights, scaled by 128.
    localparam logic [15:0] Y_R_COEF   = 16'd38;
    localparam logic [15:0] Y_G_COEF   = 16'd75;
    localparam logic [15:0] Y_B_COEF   = 16'd15;
    localparam logic [15:0] CB_R_COEF  = 16'd21;
    localparam logic [15:0] CB_G_COEF  = 16'd43;
    localparam logic [15:0] CR_G_COEF  = 16'd54;
    localparam logic [15:0] CR_B_COEF  = 16'd10;
    // Keeps the chroma sums non-negative; after the shift it is the 0x80 offset.
    localparam logic [15:0] CHROMA_BIAS = 16'd16384;

endpackage

// ----- rtl/bqy_if.sv -----
// Valid/ready channels of the Bayer quad to YCbCr unit.
// Depends on bqy_pkg for the beat layouts.
interface bqy_win_if;
    logic                 valid;
    logic                 ready;
    bqy_pkg::t_win_beat   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bqy_pix_if;
    logic                 valid;
    logic                 ready;
    bqy_pkg::t_pix_beat   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/bayer_quad_to_ycbcr_unit.sv -----
// Bayer quad demosaic and YCbCr conversion: an accepted window beat passes
// through the window register and then the output register to its pixel beat
// on o_pix; throughput one quad per cycle while o_pix.ready stays high.
// The window register feeds short demosaic and constant-weight logic that lands
// in the output register; each stage advances when the stage after it is empty
// or is being drained, so a held result stalls the input only once the window
// stage behind it is full too.
// Synchronous active-low reset clears both stage valid bits; payload is not reset.
module bayer_quad_to_ycbcr_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bqy_win_if.sink       i_win,
    bqy_pix_if.source     o_pix
);
    import bqy_pkg::*;

    // Truncating byte average.
    function automatic logic [7:0] avg2(input logic [7:0] p, input logic [7:0] q);
        logic [8:0] sum;
        begin
            sum = {1'b0, p} + {1'b0, q};
            return sum[8:1];
        end
    endfunction

    // RGB to YCbCr with weights scaled by 128; all sums fit in 15 bits.
    function automatic t_ycbcr to_ycbcr(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b);
        logic [15:0] y_sum;
        logic [15:0] cb_sum;
        logic [15:0] cr_sum;
        t_ycbcr      res;
        begin
            y_sum  = Y_R_COEF * {8'd0, r} + Y_G_COEF * {8'd0, g} + Y_B_COEF * {8'd0, b};
            cb_sum = ({2'd0, b, 6'd0} + CHROMA_BIAS)
                     - (CB_R_COEF * {8'd0, r} + CB_G_COEF * {8'd0, g});
            cr_sum = ({2'd0, r, 6'd0} + CHROMA_BIAS)
                     - (CR_G_COEF * {8'd0, g} + CR_B_COEF * {8'd0, b});
            res.luma      = y_sum[14:7];
            res.blue_diff = cb_sum[14:7];
            res.red_diff  = cr_sum[14:7];
            return res;
        end
    endfunction

    // ---------------------------------------------------------------------
    // Stage control
    // ---------------------------------------------------------------------
    logic       r_s1_valid;
    t_win_beat  r_s1_win;
    logic       r_out_valid;
    t_pix_beat  r_out_pix;

    logic       s2_ready;   // output register can take a new result
    logic       s1_ready;   // window register can take a new beat
    logic       n_s1_valid;
    logic       n_out_valid;

    assign s2_ready = !r_out_valid || o_pix.ready;
    assign s1_ready = !r_s1_valid || s2_ready;

    assign i_win.ready = s1_ready;
    assign o_pix.valid = r_out_valid;
    assign o_pix.data  = r_out_pix;

    always_comb begin
        // Window stage fills on an input beat, drains into the output stage.
        n_s1_valid = s1_ready ? i_win.valid : r_s1_valid;
        // Output stage fills from the window stage, empties on a taken beat.
        n_out_valid = s2_ready ? r_s1_valid : r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // ---------------------------------------------------------------------
    // Window register
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (s1_ready && i_win.valid) begin
            r_s1_win <= i_win.data;
        end
    end

    // ---------------------------------------------------------------------
    // Demosaic: row 1 is blue/green, row 2 is green/red at columns x, x+1
    // ---------------------------------------------------------------------
    logic [7:0] a [4];  // row above
    logic [7:0] b [4];  // upper quad row
    logic [7:0] c [4];  // lower quad row
    logic [7:0] d [4];  // row below
    logic [7:0] e [4];  // vertical average of rows 0 and 2
    logic [7:0] f [4];  // vertical average of rows 1 and 3

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            a[i] = r_s1_win.window_row0[8*i +: 8];
            b[i] = r_s1_win.window_row1[8*i +: 8];
            c[i] = r_s1_win.window_row2[8*i +: 8];
            d[i] = r_s1_win.window_row3[8*i +: 8];
            e[i] = avg2(a[i], c[i]);
            f[i] = avg2(b[i], d[i]);
        end
    end

    t_ycbcr px_tl;
    t_ycbcr px_tr;
    t_ycbcr px_bl;
    t_ycbcr px_br;

    // Blue site: red from the four diagonals, green from the cross.
    assign px_tl = to_ycbcr(avg2(e[0], e[2]), avg2(avg2(b[0], b[2]), e[1]), b[1]);
    // Green site in a blue row.
    assign px_tr = to_ycbcr(e[2], b[2], avg2(b[1], b[3]));
    // Green site in a red row.
    assign px_bl = to_ycbcr(avg2(c[0], c[2]), c[1], f[1]);
    // Red site: green from the cross, blue from the four diagonals.
    assign px_br = to_ycbcr(c[2], avg2(avg2(c[1], c[3]), f[2]), avg2(f[1], f[3]));

    // ---------------------------------------------------------------------
    // Output register: advance when empty or when the current beat is taken
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (s2_ready && r_s1_valid) begin
            r_out_pix.luma_top_left          <= px_tl.luma;
            r_out_pix.blue_diff_top_left     <= px_tl.blue_diff;
            r_out_pix.red_diff_top_left      <= px_tl.red_diff;
            r_out_pix.luma_top_right         <= px_tr.luma;
            r_out_pix.blue_diff_top_right    <= px_tr.blue_diff;
            r_out_pix.red_diff_top_right     <= px_tr.red_diff;
            r_out_pix.luma_bottom_left       <= px_bl.luma;
            r_out_pix.blue_diff_bottom_left  <= px_bl.blue_diff;
            r_out_pix.red_diff_bottom_left   <= px_bl.red_diff;
            r_out_pix.luma_bottom_right      <= px_br.luma;
            r_out_pix.blue_diff_bottom_right <= px_br.blue_diff;
            r_out_pix.red_diff_bottom_right  <= px_br.red_diff;
        end
    end

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    // An accepted window always lands in the window stage.
    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_win.valid && i_win.ready) |=> r_s1_valid)
        else $error("accepted window beat lost");

    // A window moving into a free output stage shows up as a result.
    a_s1_reaches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && s2_ready) |=> o_pix.valid)
        else $error("window stage did not advance into output register");

    // An empty window stage never stalls the input.
    a_empty_takes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> i_win.ready)
        else $error("input stalled with empty window stage");

    // Reset empties both stages.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_s1_valid && !o_pix.valid))
        else $error("stage valid bits not cleared by reset");

endmodule
